// ----- design/held_key_router_with_autorepeat_defines.svh -----
// ----------------------------------------------------------------------------
// held key router assertion macros
// shared assertion forms for the key router
// ----------------------------------------------------------------------------
`ifndef HELD_KEY_ROUTER_WITH_AUTOREPEAT_DEFINES_SVH
`define HELD_KEY_ROUTER_WITH_AUTOREPEAT_DEFINES_SVH

// implication checked on every edge out of reset
`define HKR_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define HKR_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/hkr_pkg.sv -----
// ----------------------------------------------------------------------------
// hkr_pkg
// types and constants of the held key router
// ----------------------------------------------------------------------------
package hkr_pkg;

    localparam logic [1:0] CMD_MENU    = 2'd0;
    localparam logic [1:0] CMD_POINTER = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_CANCEL  = 2'd3;

    localparam logic [1:0] EV_MENU    = 2'd0;
    localparam logic [1:0] EV_POINTER = 2'd1;
    localparam logic [1:0] EV_CANCEL  = 2'd2;

    localparam logic [2:0] REG_DELAY      = 3'd0;
    localparam logic [2:0] REG_INTERVAL   = 3'd1;
    localparam logic [2:0] REG_FIRST_MENU = 3'd2;
    localparam logic [2:0] REG_BACK       = 3'd3;
    localparam logic [2:0] REG_LAST_REP   = 3'd4;
    localparam logic [2:0] REG_ACCEPT     = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] source_id;
        logic [3:0]  action;
        logic        is_down;
        logic        is_repeat;
        logic        forget;
        logic [31:0] now;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [3:0] event_action;
        logic       event_down;
        logic       last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN1,
        ST_DECIDE,
        ST_SCAN2,
        ST_CHOOSE,
        ST_ADV_SCAN,
        ST_CAN_COUNT,
        ST_CAN_FIXED,
        ST_CAN_SCAN,
        ST_CAN_APPLY,
        ST_EMIT
    } t_state;

endpackage

// ----- design/held_key_router_with_autorepeat.sv -----
// ----------------------------------------------------------------------------
// held_key_router_with_autorepeat
// routes held menu and pointer sources to logical edges with auto-repeat
// ----------------------------------------------------------------------------
// One item at a time. A sequencer walks the source table one slot a cycle
// (the cancel release pass waits while the output register is not free)
// through a single compare unit: a button makes one pass for lookup and free
// slot and one for the held check and newest serial; an ignored press or
// unknown release ends after the first pass, a dropped menu command is
// discarded on accept, an advance makes one pass, and a cancel makes one pass
// to find its final result, four fixed results, and one pass emitting the
// directional releases. A ready result waits while the output register still
// holds an untaken one. Button and advance results are built in a staging
// register and move to the output register when it is free. Table fields live
// in slot-indexed registers with per-slot valid bits that reset clears.
module held_key_router_with_autorepeat
    import hkr_pkg::*;
#(
    parameter int MAX_SOURCES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CW = $clog2(MAX_SOURCES + 1);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_SOURCES - 1);

    // configuration
    logic [15:0] r_delay, r_interval;
    logic [3:0]  r_first_menu, r_back, r_last_rep, r_accept;

    // table
    logic [MAX_SOURCES-1:0] r_valid;
    logic [31:0] r_id     [MAX_SOURCES];
    logic        r_kind   [MAX_SOURCES];
    logic [3:0]  r_act    [MAX_SOURCES];
    logic        r_blk    [MAX_SOURCES];
    logic [31:0] r_serial [MAX_SOURCES];

    logic [31:0] r_press, r_now_max, r_target;
    logic [32:0] r_next_time;

    t_state      r_state, n_state;
    t_in_item    r_item;
    logic [CW-1:0] r_idx;
    logic        r_found, r_free_ok, r_held, r_ev_pend;
    logic [IW-1:0] r_found_slot, r_free_slot;
    logic        r_kind_c;
    logic [3:0]  r_act_c;
    logic [31:0] r_newest;
    logic [1:0]  r_fixed;
    t_out_item   r_ev;
    t_out_item   r_out;
    logic        r_out_valid;
    logic        r_blk_c;
    logic        r_any;
    logic [IW-1:0] r_last_slot;

    logic [IW-1:0] w_i;
    logic w_ent_v, w_ent_blk, w_ent_kind;
    logic [3:0] w_ent_act;
    logic [31:0] w_ent_id, w_ent_ser;
    logic w_repeats, w_scan_end;
    logic w_out_free;
    logic w_press_skip;
    logic w_load;

    assign w_i        = r_idx[IW-1:0];
    assign w_ent_v    = r_valid[w_i];
    assign w_ent_blk  = r_blk[w_i];
    assign w_ent_kind = r_kind[w_i];
    assign w_ent_act  = r_act[w_i];
    assign w_ent_id   = r_id[w_i];
    assign w_ent_ser  = r_serial[w_i];
    assign w_repeats  = w_ent_v && !w_ent_blk && !w_ent_kind && (w_ent_act <= r_last_rep);
    assign w_scan_end = (r_idx == LAST_IDX);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_press_skip = r_found || (r_item.is_repeat && !r_kind_c) || !r_free_ok;
    // the output register takes a new result
    assign w_load = w_out_free && ((r_state == ST_CAN_FIXED) ||
                                   (r_state == ST_CAN_SCAN && w_repeats) ||
                                   (r_state == ST_EMIT && r_ev_pend));

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_valid) n_state = ST_SCAN1;
            ST_SCAN1:     if (w_scan_end) n_state = ST_DECIDE;
            ST_DECIDE:    n_state = ST_SCAN2;
            ST_SCAN2:     if (w_scan_end) n_state = ST_CHOOSE;
            ST_CHOOSE:    n_state = ST_EMIT;
            ST_ADV_SCAN:  if (w_scan_end) n_state = ST_EMIT;
            ST_CAN_COUNT: if (w_scan_end) n_state = ST_CAN_FIXED;
            ST_CAN_FIXED: if (w_out_free && r_fixed == 2'd3) n_state = ST_CAN_SCAN;
            ST_CAN_SCAN:  if (w_scan_end && (!w_repeats || w_out_free))
                              n_state = ST_CAN_APPLY;
            ST_CAN_APPLY: n_state = ST_EMIT;
            ST_EMIT:      if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
        // first scan is shared by buttons; other commands branch at accept
        if (r_state == ST_IDLE && i_valid) begin
            priority if (i_data.command == CMD_ADVANCE) n_state = ST_ADV_SCAN;
            else if (i_data.command == CMD_CANCEL) n_state = ST_CAN_COUNT;
            else if (i_data.command == CMD_MENU &&
                     (i_data.action < r_first_menu || i_data.action > r_back))
                n_state = ST_IDLE;
            else n_state = ST_SCAN1;
        end
        if (r_state == ST_DECIDE) begin
            if (r_item.is_down && w_press_skip) n_state = ST_IDLE;
            if (!r_item.is_down && !r_found) n_state = ST_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_press <= '0;
            r_now_max <= '0;
            r_target <= '0;
            r_next_time <= '0;
            r_out_valid <= 1'b0;
            r_ev_pend <= 1'b0;
            r_delay <= 16'd320;
            r_interval <= 16'd110;
            r_first_menu <= 4'd0;
            r_back <= 4'd7;
            r_last_rep <= 4'd5;
            r_accept <= 4'd6;
            r_idx <= '0;
            r_fixed <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DELAY:      r_delay <= i_cfg_data;
                    REG_INTERVAL:   r_interval <= i_cfg_data;
                    REG_FIRST_MENU: r_first_menu <= i_cfg_data[3:0];
                    REG_BACK:       r_back <= i_cfg_data[3:0];
                    REG_LAST_REP:   r_last_rep <= i_cfg_data[3:0];
                    REG_ACCEPT:     r_accept <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (w_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    r_fixed <= '0;
                    r_ev_pend <= 1'b0;
                    if (i_valid) begin
                        r_item <= i_data;
                        r_found <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_held <= 1'b0;
                        r_any <= 1'b0;
                        r_newest <= '0;
                        r_kind_c <= (i_data.command == CMD_POINTER);
                        r_act_c <= (i_data.command == CMD_POINTER) ? r_accept : i_data.action;
                        r_blk_c <= 1'b0;
                        // clock raise, skipped for dropped menus and cancel
                        if (i_data.command != CMD_CANCEL &&
                            !(i_data.command == CMD_MENU &&
                              (i_data.action < r_first_menu || i_data.action > r_back)) &&
                            i_data.now > r_now_max)
                            r_now_max <= i_data.now;
                    end
                end
                ST_SCAN1: begin
                    if (w_ent_v && w_ent_id == r_item.source_id && !r_found) begin
                        r_found <= 1'b1;
                        r_found_slot <= w_i;
                    end
                    if (!w_ent_v && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free_slot <= w_i;
                    end
                    r_idx <= w_scan_end ? '0 : r_idx + 1'b1;
                end
                ST_DECIDE: begin
                    if (r_item.is_down) begin
                        if (!w_press_skip) begin
                            // held check before insertion
                            r_press <= (r_press == 32'hFFFF_FFFF) ? 32'd1 : r_press + 32'd1;
                            r_valid[r_free_slot] <= 1'b1;
                            r_id[r_free_slot] <= r_item.source_id;
                            r_kind[r_free_slot] <= r_kind_c;
                            r_act[r_free_slot] <= r_act_c;
                            r_blk[r_free_slot] <= 1'b1; // hidden from held scan
                            r_serial[r_free_slot] <=
                                (r_press == 32'hFFFF_FFFF) ? 32'd1 : r_press + 32'd1;
                        end
                    end else if (r_found) begin
                        r_kind_c <= r_kind[r_found_slot];
                        r_act_c <= r_act[r_found_slot];
                        r_blk_c <= r_blk[r_found_slot];
                        r_valid[r_found_slot] <= 1'b0;
                    end
                end
                ST_SCAN2: begin
                    if (w_ent_v && !w_ent_blk && w_ent_kind == r_kind_c && w_ent_act == r_act_c)
                        r_held <= 1'b1;
                    // the new entry is still blocked here; it joins below
                    if ((w_repeats && w_ent_ser > r_newest) ||
                        (r_item.is_down && w_i == r_free_slot && !r_kind_c &&
                         r_act_c <= r_last_rep && w_ent_ser > r_newest))
                        r_newest <= w_ent_ser;
                    r_idx <= w_scan_end ? '0 : r_idx + 1'b1;
                end
                ST_CHOOSE: begin
                    if (r_item.is_down) r_blk[r_free_slot] <= 1'b0;
                    if (r_newest != r_target) begin
                        r_target <= r_newest;
                        r_next_time <= {1'b0, r_now_max} + {17'd0, r_delay};
                    end
                    r_ev_pend <= !r_held && !r_blk_c;
                    r_ev.event_kind <= r_kind_c ? EV_POINTER : EV_MENU;
                    r_ev.event_action <= r_act_c;
                    r_ev.event_down <= r_item.is_down;
                    r_ev.last <= 1'b1;
                end
                ST_ADV_SCAN: begin
                    if (!r_ev_pend && r_target != '0 && {1'b0, r_now_max} >= r_next_time &&
                        w_ent_v && !w_ent_blk && w_ent_ser == r_target) begin
                        r_ev_pend <= 1'b1;
                        r_ev.event_kind <= w_ent_kind ? EV_POINTER : EV_MENU;
                        r_ev.event_action <= w_ent_act;
                        r_ev.event_down <= 1'b1;
                        r_ev.last <= 1'b1;
                        r_next_time <= {1'b0, r_now_max} + {17'd0, r_interval};
                    end
                    r_idx <= w_scan_end ? '0 : r_idx + 1'b1;
                end
                ST_CAN_COUNT: begin
                    // the last directional release carries the last flag
                    if (w_repeats) begin
                        r_any <= 1'b1;
                        r_last_slot <= w_i;
                    end
                    r_idx <= w_scan_end ? '0 : r_idx + 1'b1;
                end
                ST_CAN_FIXED: begin
                    if (w_out_free) begin
                        r_out.event_down <= 1'b0;
                        r_out.last <= (r_fixed == 2'd3) && !r_any;
                        unique case (r_fixed)
                            2'd0: begin
                                r_out.event_kind <= EV_CANCEL;
                                r_out.event_action <= r_accept;
                            end
                            2'd1: begin
                                r_out.event_kind <= EV_MENU;
                                r_out.event_action <= r_accept;
                            end
                            2'd2: begin
                                r_out.event_kind <= EV_MENU;
                                r_out.event_action <= r_back;
                            end
                            default: begin
                                r_out.event_kind <= EV_POINTER;
                                r_out.event_action <= r_accept;
                            end
                        endcase
                        r_fixed <= r_fixed + 2'd1;
                    end
                end
                ST_CAN_SCAN: begin
                    if (!w_repeats) begin
                        r_idx <= w_scan_end ? r_idx : r_idx + 1'b1;
                    end else if (w_out_free) begin
                        r_out.event_kind <= EV_MENU;
                        r_out.event_action <= w_ent_act;
                        r_out.event_down <= 1'b0;
                        r_out.last <= (w_i == r_last_slot);
                        r_idx <= w_scan_end ? r_idx : r_idx + 1'b1;
                    end
                end
                ST_CAN_APPLY: begin
                    for (int k = 0; k < MAX_SOURCES; k++) begin
                        if (r_item.forget) r_valid[k] <= 1'b0;
                        else if (r_valid[k]) r_blk[k] <= 1'b1;
                    end
                    r_target <= '0;
                end
                ST_EMIT: begin
                    if (w_load) r_out <= r_ev;
                end
                default: ;
            endcase
        end
    end

`include "held_key_router_with_autorepeat_defines.svh"

    `HKR_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == ST_IDLE, "ready outside idle")
    `HKR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped")
    `HKR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_data), "result changed")

endmodule
